// File: design/lcns_pkg.sv
// Shared types and constants for the legato chord note sequencer.
`timescale 1ns / 1ps
`default_nettype none
package lcns_pkg;

	localparam int NOTE_W            = 7;
	localparam int VEL_W             = 7;
	localparam int CNT_W             = 4;
	localparam int NOTE_PORTS        = 8;
	localparam int MAX_NOTES_DEFAULT = 8;
	localparam logic [VEL_W-1:0] VEL_RESET = 7'd102;

	typedef logic [NOTE_W-1:0] note_t;

	typedef enum logic [1:0] {
		KIND_PRESS   = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_STRUM   = 2'd2,
		KIND_MUTE    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_EMIT
	} state_t;

	// Event context seen by every lane.
	typedef struct packed {
		kind_t            kind;
		logic [CNT_W-1:0] cnt;
		logic [CNT_W-1:0] n;
		logic             down;
	} lane_ctl_t;

	// Per-lane result: one off-pass slot, one on-pass slot, position match.
	typedef struct packed {
		logic  lo_emit;
		note_t lo_note;
		logic  hi_emit;
		note_t hi_note;
		logic  match;
	} lane_res_t;

endpackage
`default_nettype wire

// File: design/lcns_lane.sv
// One note lane: membership checks and slot selection for one chord position.
`timescale 1ns / 1ps
`default_nettype none
module lcns_lane #(
	parameter int CAP   = 8,
	parameter int INDEX = 0
) (
	input  lcns_pkg::lane_ctl_t ctl,
	input  lcns_pkg::note_t     chord [CAP],
	input  lcns_pkg::note_t     act   [CAP],
	output lcns_pkg::lane_res_t res
);
	import lcns_pkg::*;

	localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

	logic             in_chord;
	logic             in_act;
	logic             lt_n;
	logic             lt_cnt;
	logic [CNT_W-1:0] ridx;
	note_t            rnote;
	note_t            snote;

	always_comb begin
		in_chord = 1'b0;
		in_act   = 1'b0;
		rnote    = '0;
		ridx     = ctl.n - IDX - CNT_W'(1);
		for (int k = 0; k < CAP; k++) begin
			if ((CNT_W'(k) < ctl.cnt) && (chord[k] == act[INDEX]))
				in_chord = 1'b1;
			if ((CNT_W'(k) < ctl.n) && (act[k] == chord[INDEX]))
				in_act = 1'b1;
			// mirrored position for a down strum
			if (CNT_W'(k) == ridx)
				rnote = act[k];
		end
		lt_n   = IDX < ctl.n;
		lt_cnt = IDX < ctl.cnt;
		snote  = ctl.down ? rnote : act[INDEX];

		res.match   = act[INDEX] == chord[INDEX];
		res.lo_emit = 1'b0;
		res.lo_note = act[INDEX];
		res.hi_emit = 1'b0;
		res.hi_note = chord[INDEX];
		unique case (ctl.kind)
			KIND_PRESS: begin
				res.lo_emit = lt_n && !in_chord;
				res.hi_emit = lt_cnt && !in_act;
			end
			KIND_RELEASE: begin
				res.lo_note = chord[INDEX];
				res.lo_emit = lt_cnt;
			end
			KIND_STRUM: begin
				res.lo_note = snote;
				res.hi_note = snote;
				res.lo_emit = lt_n;
				res.hi_emit = lt_n;
			end
			KIND_MUTE: begin
				res.lo_emit = lt_n;
			end
			default: begin
				res.lo_emit = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: design/lcns_pick.sv
// Merge stage: picks the next pending message slot and flags the final one.
`timescale 1ns / 1ps
`default_nettype none
module lcns_pick #(
	parameter int N = 16
) (
	input  logic [N-1:0]         mask,
	output logic                 found,
	output logic [$clog2(N)-1:0] idx,
	output logic                 last
);
	import lcns_pkg::*;

	always_comb begin
		idx = '0;
		// scan from the top so the lowest pending slot wins
		for (int k = N - 1; k >= 0; k--) begin
			if (mask[k])
				idx = ($clog2(N))'(k);
		end
		found = |mask;
		last  = found && ((mask & (mask - N'(1))) == '0);
	end

endmodule
`default_nettype wire

// File: design/legato_chord_note_sequencer.sv
// Top level: item capture, note lanes, slot queue and message output.
// Flow: an accepted item is registered, evaluated into up to 2*CAP slots, then
// drained one message per cycle through the single output register while
// it is not held by out_stall; a new item is taken only back in idle.
// Reset: active chord count cleared, default velocity 102, stored notes
// undefined until a press writes them.
`timescale 1ns / 1ps
`default_nettype none
module legato_chord_note_sequencer #(
	parameter int MAX_NOTES = lcns_pkg::MAX_NOTES_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lcns_pkg::VEL_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   kind,
	input  logic [lcns_pkg::CNT_W-1:0]   note_count,
	input  logic [lcns_pkg::NOTE_W-1:0]  note_0,
	input  logic [lcns_pkg::NOTE_W-1:0]  note_1,
	input  logic [lcns_pkg::NOTE_W-1:0]  note_2,
	input  logic [lcns_pkg::NOTE_W-1:0]  note_3,
	input  logic [lcns_pkg::NOTE_W-1:0]  note_4,
	input  logic [lcns_pkg::NOTE_W-1:0]  note_5,
	input  logic [lcns_pkg::NOTE_W-1:0]  note_6,
	input  logic [lcns_pkg::NOTE_W-1:0]  note_7,
	input  logic [lcns_pkg::VEL_W-1:0]   strum_velocity,
	input  logic                         strum_down,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [lcns_pkg::NOTE_W-1:0]  note,
	output logic                         is_note_on,
	output logic [lcns_pkg::VEL_W-1:0]   velocity,
	output logic                         last
);
	import lcns_pkg::*;

	localparam int CAP   = (MAX_NOTES < NOTE_PORTS) ? MAX_NOTES : NOTE_PORTS;
	localparam int SLOTS = 2 * CAP;
	localparam int SW    = $clog2(SLOTS);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

	state_t state_q, state_d;

	logic [VEL_W-1:0] dvel_q;
	kind_t            kind_q;
	logic [CNT_W-1:0] cnt_q;
	note_t            chord_q [CAP];
	logic [VEL_W-1:0] svel_q;
	logic             down_q;

	note_t            act_q [CAP];
	logic [CNT_W-1:0] act_cnt_q;

	note_t            slot_note_q [SLOTS];
	logic [SLOTS-1:0] mask_q;
	logic [VEL_W-1:0] evt_vel_q;

	logic             out_valid_q;
	note_t            note_q;
	logic             on_q;
	logic [VEL_W-1:0] vel_q;
	logic             last_q;

	note_t            in_notes [NOTE_PORTS];
	logic [CNT_W-1:0] cnt_in;
	lane_ctl_t        ctl;
	lane_res_t        res [CAP];
	logic [SLOTS-1:0] mask_d;
	logic             same;
	logic             pick_found;
	logic [SW-1:0]    pick_idx;
	logic             pick_last;
	logic             out_free;
	logic             accept;
	logic             eval;
	logic             advance;

	assign in_notes[0] = note_0;
	assign in_notes[1] = note_1;
	assign in_notes[2] = note_2;
	assign in_notes[3] = note_3;
	assign in_notes[4] = note_4;
	assign in_notes[5] = note_5;
	assign in_notes[6] = note_6;
	assign in_notes[7] = note_7;

	assign cnt_in    = (note_count > CAP_CNT) ? CAP_CNT : note_count;
	assign cfg_ready = 1'b1;

	assign ctl.kind = kind_q;
	assign ctl.cnt  = cnt_q;
	assign ctl.n    = act_cnt_q;
	assign ctl.down = down_q;

	for (genvar i = 0; i < CAP; i++) begin : g_lane
		lcns_lane #(
			.CAP   (CAP),
			.INDEX (i)
		) u_lane (
			.ctl   (ctl),
			.chord (chord_q),
			.act   (act_q),
			.res   (res[i])
		);
		assign mask_d[i]       = res[i].lo_emit;
		assign mask_d[CAP + i] = res[i].hi_emit;
	end

	always_comb begin
		same = cnt_q == act_cnt_q;
		for (int i = 0; i < CAP; i++) begin
			if ((CNT_W'(i) < cnt_q) && !res[i].match)
				same = 1'b0;
		end
	end

	lcns_pick #(
		.N (SLOTS)
	) u_pick (
		.mask  (mask_q),
		.found (pick_found),
		.idx   (pick_idx),
		.last  (pick_last)
	);

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		accept   = 1'b0;
		eval     = 1'b0;
		advance  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				accept   = in_valid;
				if (in_valid)
					state_d = ST_EVAL;
			end
			ST_EVAL: begin
				eval    = 1'b1;
				state_d = (mask_d == '0) ? ST_IDLE : ST_EMIT;
			end
			ST_EMIT: begin
				advance = pick_found && out_free;
				if (!pick_found || (advance && pick_last))
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dvel_q      <= VEL_RESET;
			act_cnt_q   <= '0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready)
				dvel_q <= cfg_data;
			if (eval) begin
				mask_q <= mask_d;
				unique case (kind_q)
					KIND_PRESS:   act_cnt_q <= cnt_q;
					KIND_RELEASE: if (same) act_cnt_q <= '0;
					KIND_STRUM:   act_cnt_q <= act_cnt_q;
					KIND_MUTE:    act_cnt_q <= '0;
					default:      act_cnt_q <= act_cnt_q;
				endcase
			end else if (advance) begin
				mask_q[pick_idx] <= 1'b0;
			end
			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_t'(kind);
			cnt_q  <= cnt_in;
			svel_q <= strum_velocity;
			down_q <= strum_down;
			for (int i = 0; i < CAP; i++)
				chord_q[i] <= in_notes[i];
		end
		if (eval) begin
			for (int i = 0; i < CAP; i++) begin
				slot_note_q[i]       <= res[i].lo_note;
				slot_note_q[CAP + i] <= res[i].hi_note;
			end
			evt_vel_q <= (kind_q == KIND_STRUM) ? svel_q : dvel_q;
			if (kind_q == KIND_PRESS) begin
				for (int i = 0; i < CAP; i++)
					act_q[i] <= chord_q[i];
			end
		end
		// upper half of the slots is the note-on pass
		if (advance) begin
			note_q <= slot_note_q[pick_idx];
			on_q   <= pick_idx >= SW'(CAP);
			vel_q  <= (pick_idx >= SW'(CAP)) ? evt_vel_q : '0;
			last_q <= pick_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign note       = note_q;
	assign is_note_on = on_q;
	assign velocity   = vel_q;
	assign last       = last_q;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		act_cnt_q <= CAP_CNT)
		else $error("active count above capacity");

	a_emit_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (mask_q != '0))
		else $error("emit state with no pending slot");

	a_eval_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_EVAL))
		else $error("accepted item not evaluated");

	a_no_load_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !advance)
		else $error("output register overwritten while stalled");

endmodule
`default_nettype wire
